>>> rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and types for the quaternion to euler angle block.
// ----------------------------------------------------------------------------
package qte_pkg;

	// default number of cordic micro-rotations
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_TABLE_LEN   = 32;

	// widths of the quadratic terms and the cordic datapath
	localparam int SUM_W  = 34;
	localparam int REM_W  = 61;
	localparam int ROOT_W = 31;
	localparam int CORD_W = 38;
	localparam int ANG_W  = 24;

	// pipeline depths of the fixed parts
	localparam int QUAD_LAT = 3;
	localparam int SQRT_LAT = 31;

	// angle constants
	localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam int PI_Q13      = 25736;
	localparam int HALF_PI_Q13 = 12868;

	// atan(2^-i) at a 2^-20 scale
	localparam logic signed [ANG_W-1:0] ATAN_Q20 [ATAN_TABLE_LEN] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
		24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
		24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
		24'sd256,    24'sd128,    24'sd64,     24'sd32,
		24'sd16,     24'sd8,      24'sd4,      24'sd2,
		24'sd1,      24'sd0,      24'sd0,      24'sd0,
		24'sd0,      24'sd0,      24'sd0,      24'sd0,
		24'sd0,      24'sd0,      24'sd0,      24'sd0
	};

	// quadratic terms handed from the front end to the angle units
	typedef struct packed {
		logic signed [SUM_W-1:0] sr;
		logic signed [SUM_W-1:0] cr;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] cy;
		logic signed [SUM_W-1:0] sp;
		logic                    clamp;
	} qte_terms_t;

endpackage

>>> rtl/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels for quaternion input and euler angle output.
// ----------------------------------------------------------------------------
interface qte_quat_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               pitch_clamped;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		output ready);
endinterface

>>> rtl/qte_quad.sv
// ----------------------------------------------------------------------------
// qte_quad
// Quadratic product terms of the quaternion and the radicand 1 - s^2 for pitch.
// ----------------------------------------------------------------------------
module qte_quad import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [15:0]      w,
	input  logic signed [15:0]      x,
	input  logic signed [15:0]      y,
	input  logic signed [15:0]      z,
	output qte_terms_t              terms,
	output logic        [REM_W-1:0] rem
);

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	qte_terms_t         t_s2, t_s3;
	logic        [29:0] mag_s2;
	logic   [REM_W-1:0] rem_s3;

	logic signed [SUM_W+1:0] sr_c, cr_c, sy_c, cy_c, sp_c;
	logic signed [SUM_W+1:0] mag_c;
	logic                    clamp_c;
	logic              [59:0] sq_c;

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
		end
	end

	// sums at a 2^-30 scale
	always_comb begin
		sr_c = 36'(wx_s1) + 36'(yz_s1);
		sr_c = sr_c <<< 1;
		cr_c = 36'(xx_s1) + 36'(yy_s1);
		cr_c = (36'sd1 <<< 30) - (cr_c <<< 1);
		sy_c = 36'(wz_s1) + 36'(xy_s1);
		sy_c = sy_c <<< 1;
		cy_c = 36'(yy_s1) + 36'(zz_s1);
		cy_c = (36'sd1 <<< 30) - (cy_c <<< 1);
		sp_c = 36'(wy_s1) - 36'(zx_s1);
		sp_c = sp_c <<< 1;
		mag_c = sp_c[SUM_W+1] ? -sp_c : sp_c;
		clamp_c = mag_c >= (36'sd1 <<< 30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2.sr    <= SUM_W'(sr_c);
			t_s2.cr    <= SUM_W'(cr_c);
			t_s2.sy    <= SUM_W'(sy_c);
			t_s2.cy    <= SUM_W'(cy_c);
			t_s2.sp    <= SUM_W'(sp_c);
			t_s2.clamp <= clamp_c;
			mag_s2     <= clamp_c ? 30'd0 : mag_c[29:0];
		end
	end

	// radicand 2^60 - s^2
	assign sq_c = mag_s2 * mag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3   <= t_s2;
			rem_s3 <= (REM_W'(1) << 60) - REM_W'(sq_c);
		end
	end

	assign terms = t_s3;
	assign rem   = rem_s3;

endmodule

>>> rtl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Floor integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [REM_W-1:0]   rem,
	output logic [ROOT_W-1:0]  root
);

	logic [REM_W-1:0] n_s    [0:SQRT_LAT];
	logic [61:0]      root_s [0:SQRT_LAT];

	assign n_s[0]    = rem;
	assign root_s[0] = '0;

	// one digit step per stage, trial bit 4^(30-j)
	for (genvar j = 0; j < SQRT_LAT; j++) begin : g_step
		localparam logic [62:0] TRIAL = 63'(1) << (2 * (SQRT_LAT - 1 - j));
		logic [62:0] sum_c;
		assign sum_c = {1'b0, root_s[j]} + TRIAL;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, n_s[j]} >= sum_c) begin
					n_s[j+1]    <= REM_W'({2'b00, n_s[j]} - sum_c);
					root_s[j+1] <= 62'((root_s[j] >> 1) + TRIAL);
				end else begin
					n_s[j+1]    <= n_s[j];
					root_s[j+1] <= root_s[j] >> 1;
				end
			end
		end
	end

	assign root = root_s[SQRT_LAT][ROOT_W-1:0];

endmodule

>>> rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring cordic atan2, rounded and saturated to Q3.13.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF,
	parameter int LIMIT = PI_Q13
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CORD_W-1:0] y_in,
	input  logic signed [CORD_W-1:0] x_in,
	output logic signed [15:0]       angle
);

	localparam int NS = (STEPS < ATAN_TABLE_LEN) ? STEPS : ATAN_TABLE_LEN;

	logic signed [CORD_W-1:0] x_s    [0:NS];
	logic signed [CORD_W-1:0] y_s    [0:NS];
	logic signed [ANG_W-1:0]  z_s    [0:NS];
	logic                     zero_s [0:NS];
	logic signed [15:0]       angle_q;

	// fold the left half plane into the right one
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= HALF_PI_Q20;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -HALF_PI_Q20;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	// micro-rotations, one per stage
	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_Q20[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_Q20[i];
				end
			end
		end
	end

	// round to Q3.13 and saturate
	logic signed [ANG_W:0] zp_c;
	logic signed [ANG_W:0] zr_c;
	localparam logic signed [ANG_W:0] LIM = (ANG_W+1)'(LIMIT);

	always_comb begin
		zp_c = {z_s[NS][ANG_W-1], z_s[NS]} + (ANG_W+1)'(64);
		zr_c = zp_c >>> 7;
		if (zero_s[NS]) begin
			zr_c = '0;
		end else if (zr_c > LIM) begin
			zr_c = LIM;
		end else if (zr_c < -LIM) begin
			zr_c = -LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= zr_c[15:0];
		end
	end

	assign angle = angle_q;

	// x and y are the only values that leave the last rotation unused
	logic unused_c;
	assign unused_c = ^{x_s[NS], y_s[NS]};

endmodule

>>> rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Attitude quaternion in, roll, pitch and yaw out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   quat_in carries one quaternion (w, x, y, z, signed Q1.15) per transaction;
//   euler_out returns roll and yaw (signed Q3.13) and pitch (signed Q2.13) in
//   radians and a flag that is set when the pitch sine reached magnitude one
//   and pitch was held at +-pi/2.
//   The pipeline runs through the product, sum and radicand stages, the square
//   root stages at one result bit each, then one fold stage, CORDIC_STEPS
//   rotation stages and one rounding stage in the three parallel atan2 units.
//   Throughput is one transaction per cycle while euler_out is not stalled; each
//   pipeline stage holds its own valid bit and no item depends on another.
//   When euler_out stalls with a result waiting, the whole pipeline holds
//   and quat_in.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits, so the block comes up empty.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qte_quat_if.sink    quat_in,
	qte_euler_if.source euler_out
);

	localparam int NS  = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;
	localparam int LAT = QUAD_LAT + SQRT_LAT + NS + 2;
	localparam int TAIL = NS + 2;

	logic               en;
	logic [LAT-1:0]     vld_q;
	qte_terms_t         terms;
	logic [REM_W-1:0]   rem;
	logic [ROOT_W-1:0]  root;
	qte_terms_t         terms_d [0:SQRT_LAT];
	logic [1:0]         flag_d  [0:TAIL];
	logic signed [15:0] roll_c, pitch_c, yaw_c;

	// global advance: move whenever the output is free or being taken
	assign en            = !vld_q[LAT-1] || euler_out.ready;
	assign quat_in.ready = en;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], quat_in.valid};
		end
	end

	qte_quad u_quad (
		.clk   (clk),
		.en    (en),
		.w     (quat_in.quat_w),
		.x     (quat_in.quat_x),
		.y     (quat_in.quat_y),
		.z     (quat_in.quat_z),
		.terms (terms),
		.rem   (rem)
	);

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rem  (rem),
		.root (root)
	);

	// hold the terms alongside the square root
	assign terms_d[0] = terms;
	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_tdly
		always_ff @(posedge clk) begin
			if (en) begin
				terms_d[k+1] <= terms_d[k];
			end
		end
	end

	qte_cordic #(.STEPS(NS), .LIMIT(PI_Q13)) u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (CORD_W'(terms_d[SQRT_LAT].sr)),
		.x_in  (CORD_W'(terms_d[SQRT_LAT].cr)),
		.angle (roll_c)
	);

	qte_cordic #(.STEPS(NS), .LIMIT(PI_Q13)) u_yaw (
		.clk   (clk),
		.en    (en),
		.y_in  (CORD_W'(terms_d[SQRT_LAT].sy)),
		.x_in  (CORD_W'(terms_d[SQRT_LAT].cy)),
		.angle (yaw_c)
	);

	qte_cordic #(.STEPS(NS), .LIMIT(HALF_PI_Q13)) u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (CORD_W'(terms_d[SQRT_LAT].sp)),
		.x_in  (CORD_W'({1'b0, root})),
		.angle (pitch_c)
	);

	// clamp flag and sine sign follow the angle units
	assign flag_d[0] = {terms_d[SQRT_LAT].clamp, terms_d[SQRT_LAT].sp[SUM_W-1]};
	for (genvar k = 0; k < TAIL; k++) begin : g_fdly
		always_ff @(posedge clk) begin
			if (en) begin
				flag_d[k+1] <= flag_d[k];
			end
		end
	end

	// output
	assign euler_out.valid         = vld_q[LAT-1];
	assign euler_out.roll_angle    = roll_c;
	assign euler_out.yaw_angle     = yaw_c;
	assign euler_out.pitch_clamped = flag_d[TAIL][1];
	assign euler_out.pitch_angle   = !flag_d[TAIL][1] ? pitch_c[14:0] :
		(flag_d[TAIL][0] ? -15'(HALF_PI_Q13) : 15'(HALF_PI_Q13));

endmodule

>>> test/quaternion_to_euler_angles_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_test
// Drives quaternions through the valid/ready input with random gaps, predicts
// roll, pitch and yaw with an independent fixed-point model, and checks each
// result transaction in order. Includes a long output hold-off and a full
// drain pause.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_test;
	import qte_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 80;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
	} euler_t;

	// directed row: pitch and flag are typed in where known at a glance
	typedef struct {
		quat_t              q;
		bit                 pitch_known;
		logic signed [14:0] pitch;
		logic               clamped;
	} dir_row_t;

	logic clk;
	logic arst_n;

	qte_quat_if  quat_ch();
	qte_euler_if euler_ch();

	quaternion_to_euler_angles dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.quat_in  (quat_ch),
		.euler_out(euler_ch)
	);

	euler_t angles_pending[$];
	int     err_count;
	bit     gaps_on;
	bit     hold_req;
	int     idle_cycles;

	// atan2 at a 2^-20 scale by vectoring rotations
	function automatic longint atan2_q20(longint y, longint x);
		longint ang;
		longint t;
		longint xs;
		longint ys;
		int     n;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; ang = HALF_PI_Q20;
			end else begin
				t = -y; y = x; x = t; ang = -HALF_PI_Q20;
			end
		end
		n = CORDIC_STEPS_DEF < ATAN_TABLE_LEN ? CORDIC_STEPS_DEF : ATAN_TABLE_LEN;
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; ang += ATAN_Q20[i];
			end else begin
				x -= ys; y += xs; ang -= ATAN_Q20[i];
			end
		end
		return ang;
	endfunction

	// round 2^-20 angle to Q3.13 and saturate
	function automatic longint angle_q13(longint a, longint lim);
		longint r;
		r = (a + 64) >>> 7;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	// floor square root, digit by digit
	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic euler_t predict_euler(quat_t q);
		euler_t e;
		longint w, x, y, z;
		longint sr, cr, sy, cy, sp, mag;
		longint unsigned rem;
		w = q.w; x = q.x; y = q.y; z = q.z;
		sr = 2 * (w * x + y * z);
		cr = (64'sd1 <<< 30) - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = (64'sd1 <<< 30) - 2 * (y * y + z * z);
		sp = 2 * (w * y - z * x);
		e.roll = 16'(angle_q13(atan2_q20(sr, cr), PI_Q13));
		e.yaw  = 16'(angle_q13(atan2_q20(sy, cy), PI_Q13));
		mag = sp < 0 ? -sp : sp;
		if (mag >= (64'sd1 <<< 30)) begin
			e.pitch   = sp < 0 ? -15'(HALF_PI_Q13) : 15'(HALF_PI_Q13);
			e.clamped = 1'b1;
		end else begin
			rem = (64'd1 << 60) - 64'(mag * mag);
			e.pitch   = 15'(angle_q13(atan2_q20(sp, longint'(floor_sqrt(rem))),
				HALF_PI_Q13));
			e.clamped = 1'b0;
		end
		return e;
	endfunction

	function automatic logic signed [15:0] rand_comp(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'((int'($urandom_range(23170)) - int'($urandom_range(23170))) >>> 1);
			default: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
				: 16'sh8000 + 16'($urandom_range(3));
		endcase
	endfunction

	// mix of full-range patterns, quaternions with components of at most 11585 in magnitude and axis extremes
	function automatic quat_t rand_quat();
		quat_t q;
		int    sel;
		sel = $urandom_range(99);
		if (sel < 40) begin
			q.w = rand_comp(0); q.x = rand_comp(0); q.y = rand_comp(0); q.z = rand_comp(0);
		end else if (sel < 85) begin
			q.w = rand_comp(1); q.x = rand_comp(1); q.y = rand_comp(1); q.z = rand_comp(1);
		end else begin
			q.w = $urandom_range(1) ? rand_comp(2) : '0;
			q.x = $urandom_range(1) ? rand_comp(2) : '0;
			q.y = $urandom_range(1) ? rand_comp(2) : '0;
			q.z = $urandom_range(1) ? rand_comp(2) : '0;
		end
		return q;
	endfunction

	// offer one quaternion, record its expected angles on acceptance
	task automatic send_quat(quat_t q, euler_t exp_angles);
		if (gaps_on)
			while ($urandom_range(99) < 16) begin
				quat_ch.valid <= 1'b0;
				@(negedge clk);
			end
		quat_ch.valid  <= 1'b1;
		quat_ch.quat_w <= q.w;
		quat_ch.quat_x <= q.x;
		quat_ch.quat_y <= q.y;
		quat_ch.quat_z <= q.z;
		do @(posedge clk); while (!(quat_ch.valid && quat_ch.ready));
		angles_pending.push_back(exp_angles);
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		quat_t q;
		for (int i = 0; i < count; i++) begin
			q = rand_quat();
			send_quat(q, predict_euler(q));
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// output ready with random stalls and an occasional long hold-off
	initial begin
		euler_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				euler_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				euler_ch.ready <= gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		euler_t e;
		if (euler_ch.valid && euler_ch.ready) begin
			if (angles_pending.size() == 0) begin
				$error("unexpected result transaction");
				err_count++;
			end else begin
				e = angles_pending.pop_front();
				if (euler_ch.roll_angle !== e.roll) begin
					$error("roll_angle expected %0d got %0d", e.roll, euler_ch.roll_angle);
					err_count++;
				end
				if (euler_ch.pitch_angle !== e.pitch) begin
					$error("pitch_angle expected %0d got %0d", e.pitch, euler_ch.pitch_angle);
					err_count++;
				end
				if (euler_ch.yaw_angle !== e.yaw) begin
					$error("yaw_angle expected %0d got %0d", e.yaw, euler_ch.yaw_angle);
					err_count++;
				end
				if (euler_ch.pitch_clamped !== e.clamped) begin
					$error("pitch_clamped expected %0d got %0d", e.clamped,
						euler_ch.pitch_clamped);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("quaternion_to_euler_angles_test: errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		dir_row_t rows[];
		euler_t   e;
		quat_ch.valid  = 1'b0;
		quat_ch.quat_w = '0;
		quat_ch.quat_x = '0;
		quat_ch.quat_y = '0;
		quat_ch.quat_z = '0;
		err_count   = 0;
		idle_cycles = 0;
		gaps_on     = 1'b1;
		hold_req    = 1'b0;
		arst_n      = 1'b0;
		rows = '{
			'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd0, -16'sd32768, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd0, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, 15'sd0, 1'b0},
			'{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, 15'sd0, 1'b0},
			// pitch sine at and past one: clamped to +-pi/2
			'{'{-16'sd32768, 16'sd0, -16'sd32768, 16'sd0}, 1'b1, 15'(HALF_PI_Q13), 1'b1},
			'{'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0}, 1'b1, -15'(HALF_PI_Q13), 1'b1},
			'{'{16'sd23171, 16'sd0, 16'sd23171, 16'sd0}, 1'b1, 15'(HALF_PI_Q13), 1'b1},
			'{'{16'sd0, -16'sd23171, 16'sd0, 16'sd23171}, 1'b1, 15'(HALF_PI_Q13), 1'b1},
			// just under the clamp
			'{'{16'sd23170, 16'sd0, 16'sd23170, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd23170, 16'sd0, -16'sd23170, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			// both roll operands zero
			'{'{16'sd0, 16'sd16384, 16'sd16384, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{16'sd0, 16'sd16384, -16'sd16384, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			// negative cosine term with zero and negative sine
			'{'{16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			'{'{-16'sd100, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, 15'sd0, 1'b0},
			// alternating bit patterns
			'{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, 15'sd0, 1'b0},
			'{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, 15'sd0, 1'b0}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (rows[i]) begin
			e = predict_euler(rows[i].q);
			if (rows[i].pitch_known) begin
				e.pitch   = rows[i].pitch;
				e.clamped = rows[i].clamped;
			end
			send_quat(rows[i].q, e);
		end

		// random with gaps, then a stretch at full rate
		send_random(450);
		gaps_on = 1'b0;
		send_random(250);

		// long output hold-off while input keeps coming
		gaps_on  = 1'b1;
		hold_req = 1'b1;
		send_random(250);

		// sender pauses until the pipeline has drained
		quat_ch.valid <= 1'b0;
		wait (angles_pending.size() == 0);
		@(negedge clk);
		send_random(400);

		quat_ch.valid <= 1'b0;
		wait (angles_pending.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("quaternion_to_euler_angles_test: clean");
		else
			$display("quaternion_to_euler_angles_test: errors");
		$finish;
	end

endmodule
